[design/usb_control_td_chain_builder_top_defines.svh]
// Assertion macros used by the top-level design file.
`ifndef USB_CONTROL_TD_CHAIN_BUILDER_TOP_DEFINES_SVH
`define USB_CONTROL_TD_CHAIN_BUILDER_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS

`define UCTD_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`define UCTD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define UCTD_ASSERT_IMPL(label, ante, cons, msg)

`define UCTD_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

[design/uctd_pkg.sv]
package uctd_pkg;

  localparam int TD_LIMIT_DEF  = 30;
  localparam int TD_STRIDE_DEF = 32;
  localparam int QUEUE_DEPTH   = 2;

  localparam int CFG_IDX_W = 4;
  localparam logic [CFG_IDX_W-1:0] CFG_TD_POOL_BASE = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BOUNCE_BASE  = 4'd1;

  localparam logic [7:0] SETUP_PID = 8'h2D;
  localparam logic [7:0] PID_IN    = 8'h69;
  localparam logic [7:0] PID_OUT   = 8'hE1;

  localparam logic [31:0] ST_ACTIVE = 32'h0080_0000;
  localparam logic [31:0] ST_IOC    = 32'h0100_0000;
  localparam logic [31:0] ST_LOWSPD = 32'h0400_0000;
  localparam logic [31:0] ST_ERR3   = 32'h1800_0000;
  localparam logic [31:0] ST_SPD    = 32'h2000_0000;

  localparam logic [31:0] LINK_DEPTH  = 32'h0000_0004;
  localparam logic [31:0] LINK_END    = 32'h0000_0001;
  localparam logic [31:0] DATA_OFFSET = 32'd64;

  localparam logic [10:0] ML_ZERO    = 11'h7FF;
  localparam logic [10:0] ML_SETUP   = 11'd7;
  localparam logic [6:0]  MP_DEFAULT = 7'd8;

  typedef struct packed {
    logic [6:0]  dev_addr;
    logic        slow_dev;
    logic [6:0]  pkt_max;
    logic        dir_in;
    logic [11:0] length;
    logic        has_data;
  } req_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  function automatic logic [31:0] make_token(input logic [7:0] pid, input logic [6:0] addr,
                                             input logic toggle, input logic [10:0] ml);
    return {ml, 1'b0, toggle, 4'b0000, addr, pid};
  endfunction

endpackage

[design/uctd_front.sv]
module uctd_front (
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [6:0]           in_dev_addr,
  input  logic                 in_slow_dev,
  input  logic [6:0]           in_pkt_max,
  input  logic                 in_dir_in,
  input  logic [11:0]          in_length,
  input  uctd_pkg::q_status_t  q_status,
  output logic                 push,
  output uctd_pkg::req_t       push_data
);

  assign in_ready = !q_status.full;
  assign push     = in_valid && !q_status.full;

  always_comb begin
    push_data.dev_addr = in_dev_addr;
    push_data.slow_dev = in_slow_dev;
    push_data.pkt_max  = (in_pkt_max == 7'd0) ? uctd_pkg::MP_DEFAULT : in_pkt_max;
    push_data.dir_in   = in_dir_in;
    push_data.length   = in_length;
    push_data.has_data = (in_length != 12'd0);
  end

endmodule

[design/uctd_queue.sv]
module uctd_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  uctd_pkg::req_t       push_data,
  input  logic                 pop,
  output uctd_pkg::req_t       head,
  output uctd_pkg::q_status_t  q_status
);

  localparam int PTR_W = (uctd_pkg::QUEUE_DEPTH > 1) ? $clog2(uctd_pkg::QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(uctd_pkg::QUEUE_DEPTH + 1);

  uctd_pkg::req_t    slots_r [uctd_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              do_push, do_pop;

  assign q_status.full  = (count_r == CNT_W'(uctd_pkg::QUEUE_DEPTH));
  assign q_status.empty = (count_r == '0);
  assign do_push = push && !q_status.full;
  assign do_pop  = pop && !q_status.empty;
  assign head    = slots_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(uctd_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(uctd_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

[design/uctd_back.sv]
module uctd_back #(
  parameter int TD_LIMIT  = uctd_pkg::TD_LIMIT_DEF,
  parameter int TD_STRIDE = uctd_pkg::TD_STRIDE_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [31:0]          td_pool_base,
  input  logic [31:0]          bounce_base,
  input  uctd_pkg::req_t       head,
  input  uctd_pkg::q_status_t  q_status,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [4:0]           out_td_index,
  output logic [31:0]          out_link_word,
  output logic [31:0]          out_status_word,
  output logic [31:0]          out_token_word,
  output logic [31:0]          out_buffer_addr,
  output logic                 out_last
);

  localparam int IDX_W = $clog2(TD_LIMIT + 1);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SETUP  = 4'b0010,
    S_DATA   = 4'b0100,
    S_STATUS = 4'b1000
  } state_t;

  state_t          state_r, state_nxt;
  uctd_pkg::req_t  req_r, req_nxt;
  logic [IDX_W-1:0] n_r, n_nxt, n_inc;
  logic [11:0]     rem_r, rem_nxt, chunk, rem_left;
  logic            toggle_r, toggle_nxt;
  logic [31:0]     link_r, link_nxt;
  logic [31:0]     buf_r, buf_nxt;

  logic            out_valid_r, out_valid_nxt;
  logic [4:0]      out_idx_r, out_idx_nxt;
  logic [31:0]     out_link_r, out_link_nxt;
  logic [31:0]     out_status_r, out_status_nxt;
  logic [31:0]     out_token_r, out_token_nxt;
  logic [31:0]     out_buf_r, out_buf_nxt;
  logic            out_last_r, out_last_nxt;

  logic            slot_free, emit;
  logic [IDX_W+4:0] n_ext;
  logic [31:0]     base_st;
  logic [7:0]      pid_data, pid_status;

  assign slot_free  = !out_valid_r || out_ready;
  assign n_inc      = n_r + IDX_W'(1);
  assign n_ext      = {5'b00000, n_r};
  assign chunk      = (rem_r > {5'b00000, req_r.pkt_max}) ? {5'b00000, req_r.pkt_max}
                                                        : rem_r;
  assign rem_left   = rem_r - chunk;
  assign base_st    = uctd_pkg::ST_ACTIVE | uctd_pkg::ST_ERR3
                    | (req_r.slow_dev ? uctd_pkg::ST_LOWSPD : 32'd0);
  assign pid_data   = req_r.dir_in ? uctd_pkg::PID_IN : uctd_pkg::PID_OUT;
  assign pid_status = req_r.dir_in ? uctd_pkg::PID_OUT : uctd_pkg::PID_IN;

  always_comb begin
    state_nxt      = state_r;
    req_nxt        = req_r;
    n_nxt          = n_r;
    rem_nxt        = rem_r;
    toggle_nxt     = toggle_r;
    link_nxt       = link_r;
    buf_nxt        = buf_r;
    pop            = 1'b0;
    emit           = 1'b0;
    out_idx_nxt    = out_idx_r;
    out_link_nxt   = out_link_r;
    out_status_nxt = out_status_r;
    out_token_nxt  = out_token_r;
    out_buf_nxt    = out_buf_r;
    out_last_nxt   = out_last_r;
    case (state_r)
      S_IDLE: begin
        if (!q_status.empty) begin
          pop        = 1'b1;
          req_nxt    = head;
          n_nxt      = '0;
          rem_nxt    = head.length;
          toggle_nxt = 1'b1;
          link_nxt   = td_pool_base + 32'(TD_STRIDE);
          buf_nxt    = bounce_base + uctd_pkg::DATA_OFFSET;
          state_nxt  = S_SETUP;
        end
      end
      S_SETUP: begin
        if (slot_free) begin
          emit           = 1'b1;
          out_idx_nxt    = n_ext[4:0];
          out_link_nxt   = link_r | uctd_pkg::LINK_DEPTH;
          out_status_nxt = base_st;
          out_token_nxt  = uctd_pkg::make_token(uctd_pkg::SETUP_PID, req_r.dev_addr, 1'b0,
                                                uctd_pkg::ML_SETUP);
          out_buf_nxt    = bounce_base;
          out_last_nxt   = 1'b0;
          n_nxt          = n_inc;
          link_nxt       = link_r + 32'(TD_STRIDE);
          state_nxt      = req_r.has_data ? S_DATA : S_STATUS;
        end
      end
      S_DATA: begin
        if (slot_free) begin
          emit           = 1'b1;
          out_idx_nxt    = n_ext[4:0];
          out_link_nxt   = link_r | uctd_pkg::LINK_DEPTH;
          out_status_nxt = base_st | uctd_pkg::ST_SPD;
          out_token_nxt  = uctd_pkg::make_token(pid_data, req_r.dev_addr, toggle_r,
                                                11'(chunk - 12'd1));
          out_buf_nxt    = buf_r;
          out_last_nxt   = 1'b0;
          buf_nxt        = buf_r + {20'd0, chunk};
          rem_nxt        = rem_left;
          toggle_nxt     = !toggle_r;
          n_nxt          = n_inc;
          link_nxt       = link_r + 32'(TD_STRIDE);
          if (rem_left == 12'd0 || n_inc == IDX_W'(TD_LIMIT)) begin
            state_nxt = S_STATUS;
          end
        end
      end
      S_STATUS: begin
        if (slot_free) begin
          emit           = 1'b1;
          out_idx_nxt    = n_ext[4:0];
          out_link_nxt   = uctd_pkg::LINK_END;
          out_status_nxt = base_st | uctd_pkg::ST_IOC;
          out_token_nxt  = uctd_pkg::make_token(pid_status, req_r.dev_addr, 1'b1,
                                                uctd_pkg::ML_ZERO);
          out_buf_nxt    = 32'd0;
          out_last_nxt   = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    out_valid_nxt = emit ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r        <= req_nxt;
    n_r          <= n_nxt;
    rem_r        <= rem_nxt;
    toggle_r     <= toggle_nxt;
    link_r       <= link_nxt;
    buf_r        <= buf_nxt;
    out_idx_r    <= out_idx_nxt;
    out_link_r   <= out_link_nxt;
    out_status_r <= out_status_nxt;
    out_token_r  <= out_token_nxt;
    out_buf_r    <= out_buf_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_td_index    = out_idx_r;
  assign out_link_word   = out_link_r;
  assign out_status_word = out_status_r;
  assign out_token_word  = out_token_r;
  assign out_buffer_addr = out_buf_r;
  assign out_last        = out_last_r;

endmodule

[design/usb_control_td_chain_builder_top.sv]
// Channel  Direction  Beat contents
// in       input      dev_addr, slow_dev, pkt_max, dir_in, length
// out      output     td_index, link_word, status_word, token_word, buffer_addr, last
// cfg      input      index, data (always ready)
//
// The sequencer first loads a request from the queue, then sends its descriptors as one
// descriptor beat per cycle while the output takes them.
// Up to two requests wait in the queue, so the input can be ready while a chain is being sent.
// Reset is synchronous and active low; both configuration registers reset to zero.
// A stall on the output holds the sequencer; the input only stalls when the queue is full.
`include "usb_control_td_chain_builder_top_defines.svh"

module usb_control_td_chain_builder_top #(
  parameter int TD_LIMIT  = uctd_pkg::TD_LIMIT_DEF,
  parameter int TD_STRIDE = uctd_pkg::TD_STRIDE_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [6:0]                     in_dev_addr,
  input  logic                           in_slow_dev,
  input  logic [6:0]                     in_pkt_max,
  input  logic                           in_dir_in,
  input  logic [11:0]                    in_length,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [4:0]                     out_td_index,
  output logic [31:0]                    out_link_word,
  output logic [31:0]                    out_status_word,
  output logic [31:0]                    out_token_word,
  output logic [31:0]                    out_buffer_addr,
  output logic                           out_last,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [uctd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                    cfg_data
);

  logic [31:0]         td_pool_base_r;
  logic [31:0]         bounce_base_r;
  logic                push, pop;
  uctd_pkg::req_t      push_data, head;
  uctd_pkg::q_status_t q_status;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      td_pool_base_r <= 32'd0;
      bounce_base_r  <= 32'd0;
    end else if (cfg_valid) begin
      case (cfg_index)
        uctd_pkg::CFG_TD_POOL_BASE: td_pool_base_r <= cfg_data;
        uctd_pkg::CFG_BOUNCE_BASE:  bounce_base_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  uctd_front u_front (
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_dev_addr (in_dev_addr),
    .in_slow_dev (in_slow_dev),
    .in_pkt_max  (in_pkt_max),
    .in_dir_in   (in_dir_in),
    .in_length   (in_length),
    .q_status    (q_status),
    .push        (push),
    .push_data   (push_data)
  );

  uctd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .q_status  (q_status)
  );

  uctd_back #(
    .TD_LIMIT  (TD_LIMIT),
    .TD_STRIDE (TD_STRIDE)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .td_pool_base    (td_pool_base_r),
    .bounce_base     (bounce_base_r),
    .head            (head),
    .q_status        (q_status),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_td_index    (out_td_index),
    .out_link_word   (out_link_word),
    .out_status_word (out_status_word),
    .out_token_word  (out_token_word),
    .out_buffer_addr (out_buffer_addr),
    .out_last        (out_last)
  );

  `UCTD_ASSERT_IMPL(a_last_terminates, out_valid && out_last, (out_link_word == uctd_pkg::LINK_END) && (out_buffer_addr == 32'd0), "Last descriptor must terminate with no buffer.")
  `UCTD_ASSERT_IMPL(a_first_is_setup, out_valid && (out_td_index == 5'd0), !out_last && (out_token_word[7:0] == uctd_pkg::SETUP_PID), "Chain must open with a SETUP descriptor.")
  `UCTD_ASSERT_NEXT(a_chain_continues, out_valid && out_ready && !out_last, out_valid, "A chain must not pause between descriptors.")

endmodule

[tb/tb_usb_control_td_chain_builder_top.sv]
`timescale 1ns / 1ps

module tb_usb_control_td_chain_builder_top;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int HOLD_CYCLES    = 400;
  localparam int PHASE_ITEMS    = 32;
  localparam int SETTLE_CYCLES  = 40;

  typedef struct packed {
    logic [6:0]  dev_addr;
    logic        slow_dev;
    logic [6:0]  pkt_max;
    logic        dir_in;
    logic [11:0] length;
  } ctl_req_t;

  typedef struct packed {
    logic [4:0]  td_index;
    logic [31:0] link_word;
    logic [31:0] status_word;
    logic [31:0] token_word;
    logic [31:0] buffer_addr;
    logic        last;
  } td_desc_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [6:0]  in_dev_addr = '0;
  logic        in_slow_dev = 1'b0;
  logic [6:0]  in_pkt_max = '0;
  logic        in_dir_in = 1'b0;
  logic [11:0] in_length = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [4:0]  out_td_index;
  logic [31:0] out_link_word;
  logic [31:0] out_status_word;
  logic [31:0] out_token_word;
  logic [31:0] out_buffer_addr;
  logic        out_last;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [uctd_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  ctl_req_t pending_reqs[$];
  td_desc_t expected_tds[$];
  ctl_req_t req_on_bus;

  logic [31:0] pool_base_reg = '0;
  logic [31:0] bounce_base_reg = '0;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit start_hold = 1'b0;
  int hold_left = 0;
  int quiet_cycles = 0;

  int n_errors = 0;
  int n_reqs_sent = 0;
  int n_tds_checked = 0;
  int n_truncated = 0;
  int n_cfg_writes = 0;

  usb_control_td_chain_builder_top dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_dev_addr    (in_dev_addr),
    .in_slow_dev    (in_slow_dev),
    .in_pkt_max     (in_pkt_max),
    .in_dir_in      (in_dir_in),
    .in_length      (in_length),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_td_index   (out_td_index),
    .out_link_word  (out_link_word),
    .out_status_word(out_status_word),
    .out_token_word (out_token_word),
    .out_buffer_addr(out_buffer_addr),
    .out_last       (out_last),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic [31:0] token_of(input logic [7:0] pid, input logic [6:0] addr,
                                           input logic toggle, input logic [11:0] count);
    logic [10:0] maxlen;
    maxlen = (count == 0) ? uctd_pkg::ML_ZERO : 11'(count - 12'd1);
    return {24'h0, pid} | ({25'h0, addr} << 8) | ({31'h0, toggle} << 19)
         | ({21'h0, maxlen} << 21);
  endfunction

  task automatic push_td(input int idx, input logic [31:0] status, input logic [31:0] token,
                         input logic [31:0] buf_addr, input logic is_last);
    td_desc_t td;
    logic [31:0] next_slot;
    next_slot = pool_base_reg + (idx + 1) * uctd_pkg::TD_STRIDE_DEF;
    td.td_index    = idx[4:0];
    td.link_word   = is_last ? uctd_pkg::LINK_END : (next_slot | uctd_pkg::LINK_DEPTH);
    td.status_word = status;
    td.token_word  = token;
    td.buffer_addr = buf_addr;
    td.last        = is_last;
    expected_tds.push_back(td);
  endtask

  task automatic predict_chain(input ctl_req_t req);
    logic [6:0]  pkt;
    logic [11:0] bytes_left;
    logic [11:0] chunk;
    logic [31:0] st_base;
    logic [31:0] offset;
    logic        toggle;
    logic [7:0]  data_pid;
    logic [7:0]  status_pid;
    int          n;
    pkt        = (req.pkt_max == 0) ? uctd_pkg::MP_DEFAULT : req.pkt_max;
    bytes_left = req.length;
    st_base    = uctd_pkg::ST_ACTIVE | uctd_pkg::ST_ERR3
               | (req.slow_dev ? uctd_pkg::ST_LOWSPD : 32'h0);
    data_pid   = req.dir_in ? uctd_pkg::PID_IN : uctd_pkg::PID_OUT;
    status_pid = req.dir_in ? uctd_pkg::PID_OUT : uctd_pkg::PID_IN;
    push_td(0, st_base, token_of(uctd_pkg::SETUP_PID, req.dev_addr, 1'b0, 12'd8),
            bounce_base_reg, 1'b0);
    n      = 1;
    toggle = 1'b1;
    offset = uctd_pkg::DATA_OFFSET;
    while (bytes_left != 0 && n < uctd_pkg::TD_LIMIT_DEF) begin
      chunk = (bytes_left > {5'h0, pkt}) ? {5'h0, pkt} : bytes_left;
      push_td(n, st_base | uctd_pkg::ST_SPD, token_of(data_pid, req.dev_addr, toggle, chunk),
              bounce_base_reg + offset, 1'b0);
      offset     = offset + {20'h0, chunk};
      bytes_left = bytes_left - chunk;
      toggle     = ~toggle;
      n++;
    end
    if (bytes_left != 0) begin
      n_truncated++;
    end
    push_td(n, st_base | uctd_pkg::ST_IOC, token_of(status_pid, req.dev_addr, 1'b1, 12'd0),
            32'h0, 1'b1);
  endtask

  always @(posedge clk) begin
    bit busy;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      busy = in_valid;
      if (in_valid && in_ready) begin
        predict_chain(req_on_bus);
        n_reqs_sent++;
        busy = 1'b0;
      end
      if (!busy) begin
        if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          req_on_bus   = pending_reqs.pop_front();
          in_valid    <= 1'b1;
          in_dev_addr <= req_on_bus.dev_addr;
          in_slow_dev <= req_on_bus.slow_dev;
          in_pkt_max  <= req_on_bus.pkt_max;
          in_dir_in   <= req_on_bus.dir_in;
          in_length   <= req_on_bus.length;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (start_hold) begin
      start_hold = 1'b0;
      hold_left  = HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      n_errors++;
    end
  endtask

  always @(posedge clk) begin
    td_desc_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_tds.size() == 0) begin
        $error("descriptor beat with index %0d arrived with nothing expected", out_td_index);
        n_errors++;
      end else begin
        want = expected_tds.pop_front();
        check_field("td_index", {27'h0, want.td_index}, {27'h0, out_td_index});
        check_field("link_word", want.link_word, out_link_word);
        check_field("status_word", want.status_word, out_status_word);
        check_field("token_word", want.token_word, out_token_word);
        check_field("buffer_addr", want.buffer_addr, out_buffer_addr);
        check_field("last", {31'h0, want.last}, {31'h0, out_last});
        n_tds_checked++;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
        || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic ctl_req_t make_req(input int addr, input int ls, input int mp,
                                        input int dir, input int len);
    ctl_req_t r;
    r.dev_addr = addr[6:0];
    r.slow_dev = ls[0];
    r.pkt_max  = mp[6:0];
    r.dir_in   = dir[0];
    r.length   = len[11:0];
    return r;
  endfunction

  function automatic ctl_req_t random_req();
    ctl_req_t r;
    int unsigned pick;
    r.dev_addr = 7'($urandom_range(127));
    r.slow_dev = 1'($urandom_range(1));
    r.dir_in   = 1'($urandom_range(1));
    if ($urandom_range(9) < 5) begin
      r.pkt_max = 7'($urandom_range(127));
    end else begin
      r.pkt_max = 7'd8 << $urandom_range(3);
    end
    pick = $urandom_range(9);
    if (pick == 0) begin
      r.length = 12'd0;
    end else if (pick < 5) begin
      r.length = 12'($urandom_range(64, 1));
    end else if (pick < 8) begin
      r.length = 12'($urandom_range(512));
    end else begin
      r.length = 12'($urandom_range(4095));
    end
    return r;
  endfunction

  task automatic write_regs(input logic [31:0] pool, input logic [31:0] bounce);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= uctd_pkg::CFG_TD_POOL_BASE;
    cfg_data  <= pool;
    do @(posedge clk); while (!cfg_ready);
    pool_base_reg = pool;
    cfg_index <= uctd_pkg::CFG_BOUNCE_BASE;
    cfg_data  <= bounce;
    do @(posedge clk); while (!cfg_ready);
    bounce_base_reg = bounce;
    cfg_valid <= 1'b0;
    n_cfg_writes += 2;
  endtask

  task automatic run_phase(input int send_pct, input int recv_pct, input int n_random,
                           input bit with_hold);
    @(negedge clk);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    repeat (n_random) pending_reqs.push_back(random_req());
    if (with_hold) begin
      start_hold = 1'b1;
    end
    while (pending_reqs.size() != 0 || in_valid || expected_tds.size() != 0) begin
      @(negedge clk);
    end
    repeat (8) @(negedge clk);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Registers still hold their reset values for the directed requests.
    pending_reqs.push_back(make_req(0, 0, 0, 0, 0));
    pending_reqs.push_back(make_req(127, 1, 0, 1, 0));
    pending_reqs.push_back(make_req(5, 0, 0, 1, 20));
    pending_reqs.push_back(make_req(1, 1, 64, 0, 64));
    pending_reqs.push_back(make_req(2, 0, 64, 1, 65));
    pending_reqs.push_back(make_req(3, 0, 1, 1, 1));
    pending_reqs.push_back(make_req(4, 1, 8, 0, 232));
    pending_reqs.push_back(make_req(6, 0, 8, 1, 233));
    pending_reqs.push_back(make_req(127, 0, 127, 1, 4095));
    pending_reqs.push_back(make_req(64, 1, 1, 0, 4095));
    pending_reqs.push_back(make_req(85, 0, 0, 0, 4095));
    pending_reqs.push_back(make_req(42, 1, 65, 1, 130));
    pending_reqs.push_back(make_req(42, 0, 100, 0, 100));
    pending_reqs.push_back(make_req(7, 0, 127, 0, 2048));
    pending_reqs.push_back(make_req(33, 1, 16, 1, 4094));
    pending_reqs.push_back(make_req(0, 1, 64, 0, 1856));
    pending_reqs.push_back(make_req(10, 0, 32, 1, 7));
    run_phase(0, 0, 0, 1'b0);

    write_regs(32'h0000_0000, 32'h0000_0000);
    run_phase(0, 0, PHASE_ITEMS, 1'b1);

    write_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    run_phase(60, 0, PHASE_ITEMS, 1'b0);

    write_regs($urandom, $urandom);
    run_phase(0, 60, PHASE_ITEMS, 1'b0);

    write_regs(32'hFFFF_FF00, 32'hFFFF_FFF0);
    run_phase(31, 31, PHASE_ITEMS, 1'b0);

    write_regs($urandom, $urandom);
    run_phase(0, 0, PHASE_ITEMS, 1'b0);

    repeat (SETTLE_CYCLES) @(negedge clk);
    $display("Checked %0d descriptors from %0d control requests, %0d cut at the chain cap.",
             n_tds_checked, n_reqs_sent, n_truncated);
    $display("Used %0d register writes, wrapping addresses, mixed idling and a long stall.",
             n_cfg_writes);
    if (n_errors == 0 && expected_tds.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+design
design/uctd_pkg.sv
design/uctd_front.sv
design/uctd_queue.sv
design/uctd_back.sv
design/usb_control_td_chain_builder_top.sv
tb/tb_usb_control_td_chain_builder_top.sv
